// File: design/riff_wave_stream_parser_unit_defines.svh
// Assertion macros for the RIFF/WAVE stream parser.
// Used by wsp_front, the RTL file that carries concurrent checks; needs i_clk and i_rst_n in scope.
`ifndef RIFF_WAVE_STREAM_PARSER_UNIT_DEFINES_SVH
`define RIFF_WAVE_STREAM_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define WSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WSP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/wsp_pkg.sv
// Shared types, constants and helpers of the RIFF/WAVE stream parser.
// No dependencies.
package wsp_pkg;

    localparam logic [31:0] TAG_RIFF    = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE    = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT     = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA    = 32'h6461_7461;
    localparam logic [32:0] FMT_MIN_LEN = 33'd16;
    localparam logic [31:0] RATE_RESET  = 32'd12000;
    localparam logic [32:0] COUNT_MAX   = {33{1'b1}};
    localparam int          QUEUE_DEPTH = 2;

    localparam logic [2:0] ERR_NONE   = 3'd0;
    localparam logic [2:0] ERR_RIFF   = 3'd1;
    localparam logic [2:0] ERR_WAVE   = 3'd2;
    localparam logic [2:0] ERR_LENGTH = 3'd3;
    localparam logic [2:0] ERR_FORMAT = 3'd4;
    localparam logic [2:0] ERR_DATA2  = 3'd5;
    localparam logic [2:0] ERR_WALK   = 3'd6;

    localparam logic REG_RATE = 1'b0;

    typedef enum logic [4:0] {
        PH_HEADER   = 5'b00001,
        PH_CHUNK_HDR = 5'b00010,
        PH_FMT      = 5'b00100,
        PH_DATA     = 5'b01000,
        PH_SKIP     = 5'b10000
    } t_phase;

    typedef struct packed {
        logic               sample_valid;
        logic signed [15:0] sample_value;
        logic               file_done;
        logic [2:0]         error_code;
    } t_result;

    function automatic logic [2:0] f_flag(input logic [2:0] cur, input logic [2:0] code);
        return (cur == ERR_NONE) ? code : cur;
    endfunction

endpackage

// File: design/wsp_front.sv
// Front end: accepts file bytes, walks the header and chunks, builds one result per byte.
// Depends on wsp_pkg and the assertion macro header.
`include "riff_wave_stream_parser_unit_defines.svh"
module wsp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_file_byte,
    input  logic            i_last_byte,
    input  logic            i_full,
    input  logic [31:0]     i_expected_rate,
    output logic            o_push,
    output wsp_pkg::t_result o_result
);
    import wsp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [32:0] r_count, n_count;
    logic [31:0] r_riff, n_riff;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_clen, n_clen;
    logic [32:0] r_off, n_off;
    logic        r_data_seen, n_data_seen;
    logic [7:0]  r_low, n_low;
    logic [2:0]  r_err, n_err;
    logic [7:0]  r_fmt [16];

    logic        accept;
    logic        fmt_we;
    logic        emit;
    logic [15:0] sample;
    logic [32:0] body_len;
    logic [32:0] n_body_len;
    logic [2:0]  hdr_off;
    logic [31:0] len_base;
    logic [31:0] fmt_rate;
    logic [31:0] fmt_byte_rate;
    logic        fmt_ok;
    logic [2:0]  err;

    assign accept   = i_valid && !i_full;
    assign o_push   = accept;
    assign body_len = {1'b0, r_clen} + {32'd0, r_clen[0]};
    assign hdr_off  = r_off[2:0];
    assign fmt_rate      = {r_fmt[7], r_fmt[6], r_fmt[5], r_fmt[4]};
    assign fmt_byte_rate = {r_fmt[11], r_fmt[10], r_fmt[9], r_fmt[8]};
    assign fmt_ok = ({r_fmt[1], r_fmt[0]} == 16'd1) && ({r_fmt[3], r_fmt[2]} == 16'd1) &&
                    ({i_file_byte, r_fmt[14]} == 16'd16) && (fmt_rate == i_expected_rate) &&
                    ({1'b0, fmt_byte_rate} == {fmt_rate, 1'b0}) &&
                    ({r_fmt[13], r_fmt[12]} == 16'd2);

    always_comb begin
        n_phase     = r_phase;
        n_riff      = r_riff;
        n_tag       = r_tag;
        n_clen      = r_clen;
        n_off       = r_off;
        n_data_seen = r_data_seen;
        n_low       = r_low;
        err         = r_err;
        fmt_we      = 1'b0;
        emit        = 1'b0;
        sample      = 16'd0;
        len_base    = r_clen;
        n_body_len  = body_len;
        case (r_phase)
            PH_HEADER: begin
                if (r_count < 33'd4 || (r_count >= 33'd8 && r_count < 33'd12)) begin
                    n_tag = {r_tag[23:0], i_file_byte};
                end else if (r_count < 33'd8) begin
                    n_riff = r_riff | ({24'd0, i_file_byte} << {r_count[1:0], 3'b000});
                end
                if (r_count == 33'd3 && n_tag != TAG_RIFF) begin
                    err = f_flag(err, ERR_RIFF);
                end
                if (r_count == 33'd11) begin
                    if (n_tag != TAG_WAVE) begin
                        err = f_flag(err, ERR_WAVE);
                    end
                    n_phase = PH_CHUNK_HDR;
                    n_off   = 33'd0;
                end
            end
            PH_CHUNK_HDR: begin
                len_base = (hdr_off == 3'd0) ? 32'd0 : r_clen;
                if (!hdr_off[2]) begin
                    n_tag  = {r_tag[23:0], i_file_byte};
                    n_clen = len_base;
                end else begin
                    n_clen = len_base | ({24'd0, i_file_byte} << {hdr_off[1:0], 3'b000});
                end
                if (hdr_off == 3'd7) begin
                    n_off = 33'd0;
                    if (n_tag == TAG_FMT) begin
                        if ({1'b0, n_clen} < FMT_MIN_LEN) begin
                            err     = f_flag(err, ERR_FORMAT);
                            n_phase = PH_SKIP;
                        end else begin
                            n_phase = PH_FMT;
                        end
                    end else if (n_tag == TAG_DATA) begin
                        if (r_data_seen) begin
                            err     = f_flag(err, ERR_DATA2);
                            n_phase = PH_SKIP;
                        end else begin
                            n_data_seen = 1'b1;
                            n_phase     = PH_DATA;
                        end
                    end else begin
                        n_phase = PH_SKIP;
                    end
                    if (n_clen == 32'd0) begin
                        n_phase = PH_CHUNK_HDR;
                    end
                end else begin
                    n_off = {30'd0, hdr_off} + 33'd1;
                end
            end
            PH_FMT, PH_DATA, PH_SKIP: begin
                if (r_phase == PH_FMT && r_off < 33'd16) begin
                    fmt_we = 1'b1;
                    if (r_off == 33'd15 && !fmt_ok) begin
                        err = f_flag(err, ERR_FORMAT);
                    end
                end else if (r_phase == PH_DATA && r_off < {1'b0, r_clen}) begin
                    if (!r_off[0]) begin
                        n_low = i_file_byte;
                    end else begin
                        emit   = 1'b1;
                        sample = {i_file_byte, r_low};
                    end
                end
                n_off = r_off + 33'd1;
                if (n_off >= n_body_len) begin
                    n_phase = PH_CHUNK_HDR;
                    n_off   = 33'd0;
                end
            end
            default: begin
                n_phase = PH_HEADER;
            end
        endcase

        n_count = (r_count != COUNT_MAX) ? r_count + 33'd1 : r_count;

        if (i_last_byte) begin
            if (n_phase == PH_HEADER && n_count < 33'd4) begin
                err = f_flag(err, ERR_RIFF);
            end
            if ({1'b0, n_riff} + 33'd8 != n_count) begin
                err = f_flag(err, ERR_LENGTH);
            end
            if (n_phase == PH_HEADER) begin
                err = f_flag(err, ERR_WAVE);
            end
            if (n_phase != PH_CHUNK_HDR || n_off != 33'd0) begin
                err = f_flag(err, ERR_WALK);
            end
        end

        if (err != ERR_NONE) begin
            emit = 1'b0;
        end
        o_result.sample_valid = emit;
        o_result.sample_value = emit ? sample : 16'd0;
        o_result.file_done    = i_last_byte;
        o_result.error_code   = err;
        n_err = err;

        if (i_last_byte) begin
            n_count     = 33'd0;
            n_riff      = 32'd0;
            n_phase     = PH_HEADER;
            n_tag       = 32'd0;
            n_clen      = 32'd0;
            n_off       = 33'd0;
            n_data_seen = 1'b0;
            n_low       = 8'd0;
            n_err       = ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_count     <= 33'd0;
            r_riff      <= 32'd0;
            r_tag       <= 32'd0;
            r_clen      <= 32'd0;
            r_off       <= 33'd0;
            r_data_seen <= 1'b0;
            r_low       <= 8'd0;
            r_err       <= ERR_NONE;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_riff      <= n_riff;
            r_tag       <= n_tag;
            r_clen      <= n_clen;
            r_off       <= n_off;
            r_data_seen <= n_data_seen;
            r_low       <= n_low;
            r_err       <= n_err;
        end
    end

    // first 16 format bytes, written in order from the start of the fmt body
    always_ff @(posedge i_clk) begin
        if (accept && fmt_we) begin
            r_fmt[r_off[3:0]] <= i_file_byte;
        end
    end

    `WSP_ASSERT_NXT(a_restart, accept && i_last_byte, r_count == 33'd0 && r_err == ERR_NONE && r_phase == PH_HEADER, "state not cleared after last byte")
    `WSP_ASSERT_NXT(a_sticky, accept && !i_last_byte && r_err != ERR_NONE, r_err == $past(r_err), "sticky error changed")
    `WSP_ASSERT_IMP(a_body_bound, r_phase == PH_FMT || r_phase == PH_DATA || r_phase == PH_SKIP, r_off < body_len, "chunk body index beyond length")
    `WSP_ASSERT_IMP(a_sample_phase, o_push && o_result.sample_valid, r_phase == PH_DATA && o_result.error_code == ERR_NONE, "sample outside clean data chunk")

endmodule

// File: design/wsp_queue.sv
// Two-entry result queue between the parser front end and the output channel.
// Depends on wsp_pkg.
module wsp_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wsp_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    output wsp_pkg::t_result o_data,
    input  logic             i_stall
);
    import wsp_pkg::*;

    t_result r_mem [QUEUE_DEPTH];
    logic    r_wp, r_rp;
    logic [1:0] r_cnt;
    logic    pop;

    assign o_full  = (r_cnt == 2'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: design/riff_wave_stream_parser_unit.sv
// RIFF/WAVE stream parser: one file byte in, one result transaction out.
// Each result is registered in the queue and offered from it; one byte per cycle unless it is full.
// Throughput is set by the chunk walk update in the front end, done for each byte as it is taken.
// Synchronous active-low reset clears the walk state and the queue and sets the rate register to 12000.
// Depends on wsp_pkg, wsp_front and wsp_queue.
module riff_wave_stream_parser_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_file_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_sample_valid,
    output logic signed [15:0] o_sample_value,
    output logic        o_file_done,
    output logic [2:0]  o_error_code,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wsp_pkg::*;

    logic [31:0] r_rate;
    logic        full;
    logic        push;
    t_result     front_res;
    t_result     out_res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RATE) ? r_rate : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_RATE) begin
            r_rate <= pwdata;
        end
    end

    wsp_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .i_file_byte    (i_file_byte),
        .i_last_byte    (i_last_byte),
        .i_full         (full),
        .i_expected_rate(r_rate),
        .o_push         (push),
        .o_result       (front_res)
    );

    wsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_res),
        .o_full  (full),
        .o_valid (o_out_valid),
        .o_data  (out_res),
        .i_stall (i_out_stall)
    );

    assign o_in_stall     = full;
    assign o_sample_valid = out_res.sample_valid;
    assign o_sample_value = out_res.sample_value;
    assign o_file_done    = out_res.file_done;
    assign o_error_code   = out_res.error_code;

endmodule
